>>> rtl/l3kh_pkg.sv
// Shared types, constants and mixing functions for the lookup3 key hash.
package l3kh_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W  = 16;

    localparam logic [WORD_W-1:0] START_CONST = 32'hdeadbeef;
    localparam logic [WORD_W-1:0] MASK_ONE    = 32'h000000ff;
    localparam logic [WORD_W-1:0] MASK_TWO    = 32'h0000ffff;
    localparam logic [WORD_W-1:0] MASK_THREE  = 32'h00ffffff;

    localparam int BLOCK_WORDS = 3;
    localparam logic [1:0] WIB_LAST = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
    } t_abc;

    typedef struct packed {
        logic [BLOCK_WORDS-1:0][WORD_W-1:0] key;
        t_word seed;
        logic  first;
        logic  fin;
        logic  zero;
        logic  err;
    } t_blk;

    typedef struct packed {
        t_abc abc;
        logic zero;
        logic err;
    } t_fin;

    function automatic t_word rotl(input t_word x, input int unsigned k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

    function automatic t_word tail_mask(input logic [1:0] n);
        t_word m;
        unique case (n)
            2'd0: m = '0;
            2'd1: m = MASK_ONE;
            2'd2: m = MASK_TWO;
            2'd3: m = MASK_THREE;
        endcase
        return m;
    endfunction

    function automatic t_abc mix_12(input t_abc s);
        t_abc r;
        r = s;
        r.a = (r.a - r.c) ^ rotl(r.c, 4);
        r.c = r.c + r.b;
        r.b = (r.b - r.a) ^ rotl(r.a, 6);
        r.a = r.a + r.c;
        return r;
    endfunction

    function automatic t_abc mix_34(input t_abc s);
        t_abc r;
        r = s;
        r.c = (r.c - r.b) ^ rotl(r.b, 8);
        r.b = r.b + r.a;
        r.a = (r.a - r.c) ^ rotl(r.c, 16);
        r.c = r.c + r.b;
        return r;
    endfunction

    function automatic t_abc mix_56(input t_abc s);
        t_abc r;
        r = s;
        r.b = (r.b - r.a) ^ rotl(r.a, 19);
        r.a = r.a + r.c;
        r.c = (r.c - r.b) ^ rotl(r.b, 4);
        r.b = r.b + r.a;
        return r;
    endfunction

    function automatic t_abc fin_12(input t_abc s);
        t_abc r;
        r = s;
        r.c = (r.c ^ r.b) - rotl(r.b, 14);
        r.a = (r.a ^ r.c) - rotl(r.c, 11);
        return r;
    endfunction

    function automatic t_abc fin_34(input t_abc s);
        t_abc r;
        r = s;
        r.b = (r.b ^ r.a) - rotl(r.a, 25);
        r.c = (r.c ^ r.b) - rotl(r.b, 16);
        return r;
    endfunction

    function automatic t_abc fin_56(input t_abc s);
        t_abc r;
        r = s;
        r.a = (r.a ^ r.c) - rotl(r.c, 4);
        r.b = (r.b ^ r.a) - rotl(r.a, 14);
        return r;
    endfunction

    function automatic t_word fin_7(input t_abc s);
        return (s.c ^ s.b) - rotl(s.b, 24);
    endfunction

endpackage

>>> rtl/l3kh_if.sv
// Valid/ready stream interfaces for key words and hash results.
interface l3kh_in_if;
    logic                        valid;
    logic                        ready;
    logic [l3kh_pkg::WORD_W-1:0] data_word;
    logic [l3kh_pkg::LEN_W-1:0]  key_length;
    logic                        last_word;

    modport source(output valid, output data_word, output key_length, output last_word,
                   input ready);
    modport sink(input valid, input data_word, input key_length, input last_word,
                 output ready);
endinterface

interface l3kh_out_if;
    logic                        valid;
    logic                        ready;
    logic [l3kh_pkg::WORD_W-1:0] hash_value;
    logic                        length_error;

    modport source(output valid, output hash_value, output length_error, input ready);
    modport sink(input valid, input hash_value, input length_error, output ready);
endinterface

>>> rtl/l3kh_front.sv
// Front end: takes key words, masks tails, packs 12-byte blocks and checks length.
module l3kh_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  l3kh_pkg::t_word   i_cfg_wdata,
    l3kh_in_if.sink           i_in,
    input  logic              i_q_ready,
    output logic              o_push,
    output l3kh_pkg::t_blk    o_blk
);

    localparam int BW = LENGTH_BITS + 1;
    localparam logic [BW-1:0] BT_MAX = {BW{1'b1}};
    localparam logic [BW-1:0] BT_STEP = BW'(4);
    localparam logic [BW-1:0] BT_RND = BW'(3);

    l3kh_pkg::t_word                                        r_init;
    logic                                                   r_started;
    logic                                                   r_first;
    logic [1:0]                                             r_wib;
    logic [BW-1:0]                                          r_bt;
    logic [LENGTH_BITS-1:0]                                 r_held;
    l3kh_pkg::t_word                                        r_seed;
    logic [l3kh_pkg::BLOCK_WORDS-1:0][l3kh_pkg::WORD_W-1:0] r_key;

    logic                                                   w_accept;
    logic [LENGTH_BITS+l3kh_pkg::LEN_W-1:0]                 w_len_ext;
    logic [LENGTH_BITS-1:0]                                 w_held;
    logic [BW-1:0]                                          w_held_x;
    l3kh_pkg::t_word                                        w_seed;
    logic [BW:0]                                            w_sum;
    logic [BW-1:0]                                          w_bt_next;
    logic                                                   w_add;
    logic                                                   w_full;
    l3kh_pkg::t_word                                        w_val;
    logic [l3kh_pkg::BLOCK_WORDS-1:0][l3kh_pkg::WORD_W-1:0] w_key;
    logic                                                   w_mix;
    logic [BW-1:0]                                          w_up;
    logic [BW-1:0]                                          w_expect;
    logic                                                   w_err;

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = i_q_ready;

    assign w_len_ext = {{LENGTH_BITS{1'b0}}, i_in.key_length};
    assign w_held    = r_started ? r_held : w_len_ext[LENGTH_BITS-1:0];
    assign w_held_x  = BW'(w_held);
    assign w_seed    = r_started ? r_seed
                     : l3kh_pkg::START_CONST + l3kh_pkg::WORD_W'(w_held) + r_init;

    assign w_sum     = {1'b0, r_bt} + {1'b0, BT_STEP};
    assign w_bt_next = w_sum[BW] ? BT_MAX : w_sum[BW-1:0];
    assign w_add     = r_bt < w_held_x;
    assign w_full    = w_sum <= {1'b0, w_held_x};
    assign w_val     = w_full ? i_in.data_word
                     : (i_in.data_word & l3kh_pkg::tail_mask(w_held[1:0]));

    always_comb begin
        w_key = r_key;
        if (w_add) begin
            w_key[r_wib] = w_val;
        end
    end

    assign w_mix    = (r_wib == l3kh_pkg::WIB_LAST) && (w_bt_next < w_held_x);
    assign w_up     = (w_held_x + BT_RND) & ~BT_RND;
    assign w_expect = (w_up < BT_STEP) ? BT_STEP : w_up;
    assign w_err    = w_bt_next != w_expect;

    assign o_push     = w_accept && (i_in.last_word || w_mix);
    assign o_blk.key  = w_key;
    assign o_blk.seed = w_seed;
    assign o_blk.first = r_first;
    assign o_blk.fin  = i_in.last_word;
    assign o_blk.err  = w_err;
    assign o_blk.zero = w_err || (w_held == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_started <= 1'b0;
            r_first   <= 1'b1;
            r_wib     <= '0;
            r_bt      <= '0;
            r_held    <= '0;
            r_seed    <= '0;
            r_key     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
            if (w_accept) begin
                if (i_in.last_word) begin
                    r_started <= 1'b0;
                    r_first   <= 1'b1;
                    r_wib     <= '0;
                    r_bt      <= '0;
                    r_held    <= '0;
                    r_key     <= '0;
                end else begin
                    r_started <= 1'b1;
                    r_held    <= w_held;
                    r_seed    <= w_seed;
                    r_bt      <= w_bt_next;
                    r_wib     <= (r_wib == l3kh_pkg::WIB_LAST) ? 2'd0 : r_wib + 2'd1;
                    if (w_mix) begin
                        r_key   <= '0;
                        r_first <= 1'b0;
                    end else begin
                        r_key <= w_key;
                    end
                end
            end
        end
    end

endmodule

>>> rtl/l3kh_queue.sv
// Short block queue between the front end and the mixing unit.
module l3kh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  l3kh_pkg::t_blk i_blk,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output l3kh_pkg::t_blk o_blk
);

    l3kh_pkg::t_blk                   r_mem [l3kh_pkg::Q_DEPTH];
    logic [l3kh_pkg::Q_PTR_W-1:0]     r_wr;
    logic [l3kh_pkg::Q_PTR_W-1:0]     r_rd;
    logic [l3kh_pkg::Q_CNT_W-1:0]     r_cnt;

    assign o_ready = r_cnt != l3kh_pkg::Q_CNT_W'(l3kh_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_blk   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + l3kh_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + l3kh_pkg::Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + l3kh_pkg::Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - l3kh_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/l3kh_mix.sv
// Mixing unit: adds each block into the state and runs the block mix in three steps on non-final blocks.
module l3kh_mix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  l3kh_pkg::t_blk i_blk,
    output logic           o_pop,
    output logic           o_fin_valid,
    output l3kh_pkg::t_fin o_fin,
    input  logic           i_fin_ready
);

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_TWO   = 2'd1;
    localparam logic [1:0] P_THREE = 2'd2;

    logic [1:0]     r_phase;
    logic           r_fv;
    l3kh_pkg::t_abc r_abc;
    logic           r_zero;
    logic           r_err;

    l3kh_pkg::t_abc w_base;
    l3kh_pkg::t_abc w_sum;

    assign o_pop = i_q_valid && (r_phase == P_IDLE) && (!r_fv || i_fin_ready);

    always_comb begin
        if (i_blk.first) begin
            w_base.a = i_blk.seed;
            w_base.b = i_blk.seed;
            w_base.c = i_blk.seed;
        end else begin
            w_base = r_abc;
        end
        w_sum.a = w_base.a + i_blk.key[0];
        w_sum.b = w_base.b + i_blk.key[1];
        w_sum.c = w_base.c + i_blk.key[2];
    end

    assign o_fin_valid = r_fv;
    assign o_fin.abc   = r_abc;
    assign o_fin.zero  = r_zero;
    assign o_fin.err   = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_fv    <= 1'b0;
        end else begin
            unique case (r_phase)
                P_IDLE: begin
                    if (o_pop && !i_blk.fin) begin
                        r_phase <= P_TWO;
                    end
                end
                P_TWO:   r_phase <= P_THREE;
                P_THREE: r_phase <= P_IDLE;
                default: r_phase <= P_IDLE;
            endcase
            if (o_pop && i_blk.fin) begin
                r_fv <= 1'b1;
            end else if (i_fin_ready) begin
                r_fv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_abc <= i_blk.fin ? w_sum : l3kh_pkg::mix_12(w_sum);
            if (i_blk.fin) begin
                r_zero <= i_blk.zero;
                r_err  <= i_blk.err;
            end
        end else if (r_phase == P_TWO) begin
            r_abc <= l3kh_pkg::mix_34(r_abc);
        end else if (r_phase == P_THREE) begin
            r_abc <= l3kh_pkg::mix_56(r_abc);
        end
    end

endmodule

>>> rtl/l3kh_final.sv
// Final step pipeline: four registered stages of the lookup3 finalization, the last being the result register.
module l3kh_final (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fin_valid,
    input  l3kh_pkg::t_fin i_fin,
    output logic           o_fin_ready,
    l3kh_out_if.source     o_out
);

    logic            r_v1;
    logic            r_v2;
    logic            r_v3;
    logic            r_vo;
    l3kh_pkg::t_fin  r_s1;
    l3kh_pkg::t_fin  r_s2;
    l3kh_pkg::t_fin  r_s3;
    l3kh_pkg::t_word r_hash;
    logic            r_err;

    logic w_en1;
    logic w_en2;
    logic w_en3;
    logic w_en_o;

    assign w_en_o      = !r_vo || o_out.ready;
    assign w_en3       = !r_v3 || w_en_o;
    assign w_en2       = !r_v2 || w_en3;
    assign w_en1       = !r_v1 || w_en2;
    assign o_fin_ready = w_en1;

    assign o_out.valid        = r_vo;
    assign o_out.hash_value   = r_hash;
    assign o_out.length_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_fin_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en_o) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1.abc  <= l3kh_pkg::fin_12(i_fin.abc);
            r_s1.zero <= i_fin.zero;
            r_s1.err  <= i_fin.err;
        end
        if (w_en2) begin
            r_s2.abc  <= l3kh_pkg::fin_34(r_s1.abc);
            r_s2.zero <= r_s1.zero;
            r_s2.err  <= r_s1.err;
        end
        if (w_en3) begin
            r_s3.abc  <= l3kh_pkg::fin_56(r_s2.abc);
            r_s3.zero <= r_s2.zero;
            r_s3.err  <= r_s2.err;
        end
        if (w_en_o) begin
            r_hash <= r_s3.zero ? '0 : l3kh_pkg::fin_7(r_s3.abc);
            r_err  <= r_s3.err;
        end
    end

endmodule

>>> rtl/lookup3_key_hash_top.sv
// Top level of the lookup3 little-endian key hash.
// Throughput: one key word per cycle while the block queue has room. A 12-byte
// block followed by more key bytes runs the mix steps before the next block is
// taken; a key's final block is added unmixed. The last word passes the queue,
// the mix state, stages s1 to s3 and the result register. Synchronous active-low
// reset clears all control state and the seed register to zero; no clearing pass.
module lookup3_key_hash_top #(
    parameter int LENGTH_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  l3kh_pkg::t_word i_cfg_wdata,
    l3kh_in_if.sink         i_in,
    l3kh_out_if.source      o_out
);

    logic           w_push;
    l3kh_pkg::t_blk w_push_blk;
    logic           w_q_ready;
    logic           w_q_valid;
    logic           w_pop;
    l3kh_pkg::t_blk w_head_blk;
    logic           w_fin_valid;
    l3kh_pkg::t_fin w_fin;
    logic           w_fin_ready;

    l3kh_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (i_in),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_blk      (w_push_blk)
    );

    l3kh_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_blk  (w_push_blk),
        .o_ready(w_q_ready),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_blk  (w_head_blk)
    );

    l3kh_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_blk      (w_head_blk),
        .o_pop      (w_pop),
        .o_fin_valid(w_fin_valid),
        .o_fin      (w_fin),
        .i_fin_ready(w_fin_ready)
    );

    l3kh_final u_final (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fin_valid(w_fin_valid),
        .i_fin      (w_fin),
        .o_fin_ready(w_fin_ready),
        .o_out      (o_out)
    );

endmodule

>>> test/tb_lookup3_key_hash_top.sv
// Self-checking testbench for the lookup3 key hash with random handshake stalls.
`timescale 1ns / 1ps

module tb_lookup3_key_hash_top;

    localparam int CLK_HALF       = 6;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int PHASE_ITEMS    = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam logic [16:0] TAKEN_SAT = 17'h1ffff;

    typedef struct {
        l3kh_pkg::t_word hash;
        logic            err;
    } t_key_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    l3kh_pkg::t_word i_cfg_wdata;

    l3kh_in_if  in_if();
    l3kh_out_if out_if();

    lookup3_key_hash_top #(
        .LENGTH_BITS(l3kh_pkg::LEN_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_key_result hash_expected[$];
    int          error_count = 0;
    int          words_sent  = 0;
    int          max_gap     = 5;
    int          max_stall   = 5;
    int          quiet_cycles = 0;
    int          rx_wait     = 1;

    l3kh_pkg::t_word hash_seed;
    l3kh_pkg::t_word st_a, st_b, st_c;
    logic [1:0]      st_wib;
    logic [16:0]     st_taken;
    logic [15:0]     st_len;
    logic            st_started;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic l3kh_pkg::t_word rot32(input l3kh_pkg::t_word x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic l3kh_pkg::t_abc churn_block(input l3kh_pkg::t_abc s);
        l3kh_pkg::t_word a, b, c;
        l3kh_pkg::t_abc  r;
        a = s.a;
        b = s.b;
        c = s.c;
        a = a - c; a = a ^ rot32(c, 4);  c = c + b;
        b = b - a; b = b ^ rot32(a, 6);  a = a + c;
        c = c - b; c = c ^ rot32(b, 8);  b = b + a;
        a = a - c; a = a ^ rot32(c, 16); c = c + b;
        b = b - a; b = b ^ rot32(a, 19); a = a + c;
        c = c - b; c = c ^ rot32(b, 4);  b = b + a;
        r.a = a;
        r.b = b;
        r.c = c;
        return r;
    endfunction

    function automatic l3kh_pkg::t_word fold_hash(input l3kh_pkg::t_word a,
                                                  input l3kh_pkg::t_word b,
                                                  input l3kh_pkg::t_word c);
        c = c ^ b; c = c - rot32(b, 14);
        a = a ^ c; a = a - rot32(c, 11);
        b = b ^ a; b = b - rot32(a, 25);
        c = c ^ b; c = c - rot32(b, 16);
        a = a ^ c; a = a - rot32(c, 4);
        b = b ^ a; b = b - rot32(a, 14);
        c = c ^ b; c = c - rot32(b, 24);
        return c;
    endfunction

    task automatic clear_key_state();
        st_a       = '0;
        st_b       = '0;
        st_c       = '0;
        st_wib     = '0;
        st_taken   = '0;
        st_len     = '0;
        st_started = 1'b0;
    endtask

    task automatic predict_word(input l3kh_pkg::t_word word, input logic [15:0] len,
                                input logic last);
        l3kh_pkg::t_word seed;
        l3kh_pkg::t_word v;
        logic [16:0]     remain;
        logic [16:0]     full_len;
        l3kh_pkg::t_abc  s;
        t_key_result     res;
        if (!st_started) begin
            st_len     = len;
            seed       = l3kh_pkg::START_CONST + {16'h0, len} + hash_seed;
            st_a       = seed;
            st_b       = seed;
            st_c       = seed;
            st_wib     = '0;
            st_taken   = '0;
            st_started = 1'b1;
        end
        if (st_taken < {1'b0, st_len}) begin
            remain = {1'b0, st_len} - st_taken;
            if (remain >= 17'd4) begin
                v = word;
            end else begin
                v = word & ((32'h1 << (8 * remain[1:0])) - 32'h1);
            end
            case (st_wib)
                2'd0: st_a = st_a + v;
                2'd1: st_b = st_b + v;
                default: st_c = st_c + v;
            endcase
        end
        if (st_taken <= TAKEN_SAT - 17'd4) begin
            st_taken = st_taken + 17'd4;
        end else begin
            st_taken = TAKEN_SAT;
        end
        if (st_wib >= l3kh_pkg::WIB_LAST) begin
            if (st_taken < {1'b0, st_len}) begin
                s.a = st_a;
                s.b = st_b;
                s.c = st_c;
                s = churn_block(s);
                st_a = s.a;
                st_b = s.b;
                st_c = s.c;
            end
            st_wib = '0;
        end else begin
            st_wib = st_wib + 2'd1;
        end
        if (last) begin
            full_len = ({1'b0, st_len} + 17'd3) & ~17'd3;
            if (full_len < 17'd4) begin
                full_len = 17'd4;
            end
            res.err  = (st_taken != full_len);
            res.hash = '0;
            if (!res.err && st_len != 16'd0) begin
                res.hash = fold_hash(st_a, st_b, st_c);
            end
            hash_expected.push_back(res);
            clear_key_state();
        end
    endtask

    task automatic report_mismatch(input string what, input l3kh_pkg::t_word got,
                                   input l3kh_pkg::t_word want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        t_key_result want;
        if (hash_expected.size() == 0) begin
            report_mismatch("unexpected result", out_if.hash_value, '0);
        end else begin
            want = hash_expected.pop_front();
            if (out_if.hash_value !== want.hash) begin
                report_mismatch("hash_value", out_if.hash_value, want.hash);
            end
            if (out_if.length_error !== want.err) begin
                report_mismatch("length_error", {31'h0, out_if.length_error},
                                {31'h0, want.err});
            end
        end
    endtask

    task automatic send_word(input l3kh_pkg::t_word word, input logic [15:0] len,
                             input logic last);
        int gap;
        gap = $urandom_range(max_gap, 0);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_word  <= word;
        in_if.key_length <= len;
        in_if.last_word  <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_word(word, len, last);
        words_sent++;
    endtask

    task automatic send_key(input logic [15:0] len, input int nwords, input int fill);
        l3kh_pkg::t_word word;
        logic [15:0] len_field;
        for (int i = 0; i < nwords; i++) begin
            case (fill)
                FILL_ZERO: word = '0;
                FILL_ONES: word = '1;
                default:   word = $urandom;
            endcase
            len_field = (i == 0) ? len : 16'($urandom);
            send_word(word, len_field, i == nwords - 1);
        end
    endtask

    function automatic int words_for(input int len);
        return (len <= 4) ? 1 : (len + 3) / 4;
    endfunction

    task automatic settle_block();
        in_if.valid <= 1'b0;
        while (hash_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input l3kh_pkg::t_word value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        hash_seed = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed_keys();
        send_key(16'd0, 1, FILL_ONES);
        send_key(16'd0, 2, FILL_RANDOM);
        send_key(16'd1, 1, FILL_ONES);
        send_key(16'd2, 1, FILL_ONES);
        send_key(16'd3, 1, FILL_ONES);
        send_key(16'd4, 1, FILL_ONES);
        send_key(16'd12, 3, FILL_RANDOM);
        send_key(16'd13, 4, FILL_ONES);
        send_key(16'd8, 1, FILL_RANDOM);
        send_key(16'd4, 3, FILL_RANDOM);
        send_key(16'hffff, 1, FILL_ZERO);
        send_key(16'd24, 6, FILL_ZERO);
        settle_block();
    endtask

    task automatic test_seed_extremes();
        l3kh_pkg::t_word seeds[3];
        seeds[0] = 32'hffffffff;
        seeds[1] = 32'h80000000;
        seeds[2] = $urandom;
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_key(16'd0, 1, FILL_RANDOM);
            send_key(16'd5, 2, FILL_ONES);
            send_key(16'd12, 3, FILL_ONES);
            send_key(16'd27, 7, FILL_RANDOM);
            settle_block();
        end
    endtask

    task automatic test_random_keys();
        int stop_at;
        int phase;
        int phase_words;
        int pick;
        int len;
        int nwords;
        stop_at     = words_sent + RANDOM_ITEMS;
        phase       = 0;
        phase_words = 0;
        while (words_sent < stop_at) begin
            if (phase_words >= PHASE_ITEMS) begin
                settle_block();
                phase++;
                case (phase % 4)
                    0: write_seed($urandom);
                    1: write_seed('0);
                    2: write_seed('1);
                    default: write_seed($urandom);
                endcase
                max_gap     = (phase % 3 == 2) ? 0 : 5;
                max_stall   = (phase % 3 == 1) ? 0 : 5;
                phase_words = 0;
            end
            pick = $urandom_range(99, 0);
            if (pick < 75) begin
                len = $urandom_range(40, 0);
            end else if (pick < 95) begin
                len = $urandom_range(200, 41);
            end else begin
                len = $urandom_range(65535, 201);
            end
            nwords = words_for(len);
            if (len > 200) begin
                nwords = $urandom_range(8, 1);
            end else if ($urandom_range(99, 0) < 15) begin
                nwords = $urandom_range(nwords + 3, 1);
                if (nwords == words_for(len)) begin
                    nwords++;
                end
            end
            send_key(16'(len), nwords, FILL_RANDOM);
            phase_words += nwords;
        end
        settle_block();
        max_gap   = 5;
        max_stall = 5;
    endtask

    task automatic test_longest_keys();
        max_gap   = 0;
        max_stall = 0;
        write_seed($urandom);
        send_key(16'd1000, words_for(1000), FILL_RANDOM);
        send_key(16'hffff, 40, FILL_RANDOM);
        settle_block();
        max_gap   = 5;
        max_stall = 5;
    endtask

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (out_if.valid && out_if.ready) begin
                check_result();
                rx_wait = $urandom_range(max_stall, 0);
                out_if.ready <= (rx_wait == 0);
            end else if (rx_wait != 0) begin
                rx_wait--;
                out_if.ready <= (rx_wait == 0);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= '0;
        in_if.valid      <= 1'b0;
        in_if.data_word  <= '0;
        in_if.key_length <= '0;
        in_if.last_word  <= 1'b0;
        hash_seed = '0;
        clear_key_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_keys();
        test_seed_extremes();
        test_random_keys();
        test_longest_keys();

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> lookup3_key_hash_top.f
rtl/l3kh_pkg.sv
rtl/l3kh_if.sv
rtl/l3kh_front.sv
rtl/l3kh_queue.sv
rtl/l3kh_mix.sv
rtl/l3kh_final.sv
rtl/lookup3_key_hash_top.sv
test/tb_lookup3_key_hash_top.sv
